// ----- hdl/bsc_pkg.sv -----
package bsc_pkg;

    // fixed field widths
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int CORR_W    = 12;
    localparam int CFG_IDX_W = 2;

    // default store depth
    localparam int DEFAULT_MAX_LENGTH = 1024;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APERIODIC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO      = 2'd2;

    // configuration reset values
    localparam logic [LEN_W-1:0] RST_LENGTH    = 11'd1024;
    localparam logic             RST_APERIODIC = 1'b0;
    localparam logic             RST_AUTO      = 1'b1;

    // control from sequencer to accumulator
    typedef struct packed {
        logic clear;
        logic add;
        logic auto_sel;
    } acc_ctrl_t;

endpackage

// ----- hdl/bsc_ram.sv -----
module bsc_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,    // bit 0: a, bit 1: b
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [1:0]    rdata0,
    output logic [1:0]    rdata1
);

    logic [1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ----- hdl/bsc_accum.sv -----
module bsc_accum
    import bsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  acc_ctrl_t                ctrl,
    input  logic [1:0]               rdata0,
    input  logic [1:0]               rdata1,
    output logic signed [CORR_W-1:0] acc
);

    logic signed [CORR_W-1:0] acc_reg;
    logic signed [CORR_W-1:0] acc_next;
    logic                     other_bit;
    logic                     agree;

    // partner element: a itself in auto mode, else b
    assign other_bit = ctrl.auto_sel ? rdata1[0] : rdata1[1];
    assign agree     = (rdata0[0] == other_bit);

    // clear to zero, else an add of plus or minus one, wraps at the result width
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.add)
        begin
            acc_next = agree ? acc_reg + CORR_W'(1) : acc_reg - CORR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hdl/binary_sequence_correlator.sv -----
// load request: no result; the block is ready again in the next cycle
// query request: issues one element-pair read per cycle from the dual-read store,
//   L reads (periodic) or L - shift reads (aperiodic), then DRAIN, then the result
// out-of-range query: result in the cycle after acceptance
// one query at a time on the single accumulator; requests wait for the result handshake
// reset: asynchronous active low; config to length 1024, periodic, auto; store undefined
module binary_sequence_correlator
    import bsc_pkg::*;
#(
    parameter int MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // index[9:0], bit_a[10], bit_b[11], zero pad
    input  logic                 s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // shift[9:0], correlation[21:10], zero pad
    output logic                 m_tuser,   // shift_out_of_range
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;
    localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LENGTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [LEN_W-1:0]         len_reg;
    logic                     aper_reg;
    logic                     auto_reg;
    logic [1:0]               state_reg, state_next;
    logic [AW-1:0]            f_reg, f_next;
    logic [AW-1:0]            j_reg, j_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [IDX_W-1:0]         shift_reg, shift_next;
    logic                     oor_reg, oor_next;
    logic                     dv_reg;

    logic [CW-1:0]            len_eff;
    logic [CW-1:0]            idx_ext;
    logic [CW-1:0]            len_minus_idx;
    logic [CW-1:0]            j_inc;
    logic                     in_range;
    logic                     accept;
    logic                     is_query;
    logic                     rd_en;
    logic                     wr_en;
    logic [1:0]               rdata0, rdata1;
    logic signed [CORR_W-1:0] acc;
    acc_ctrl_t                acc_ctrl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= RST_LENGTH;
            aper_reg <= RST_APERIODIC;
            auto_reg <= RST_AUTO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LENGTH:    len_reg  <= cfg_data;
                REG_APERIODIC: aper_reg <= cfg_data[0];
                REG_AUTO:      auto_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // length saturated to store depth, request decode
    assign len_eff       = (CW'(len_reg) > MAX_LEN_C) ? MAX_LEN_C : CW'(len_reg);
    assign idx_ext       = CW'(s_tdata[IDX_W-1:0]);
    assign in_range      = (idx_ext < len_eff);
    assign len_minus_idx = len_eff - idx_ext;
    assign s_tready      = (state_reg == ST_IDLE);
    assign accept        = s_tvalid & s_tready;
    assign is_query      = (s_tuser == OP_QUERY);
    assign wr_en         = accept & (s_tuser == OP_LOAD) & in_range;
    assign rd_en         = (state_reg == ST_RUN);
    assign j_inc         = CW'(j_reg) + CW'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        f_next     = f_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        oor_next   = oor_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    shift_next = s_tdata[IDX_W-1:0];
                    oor_next   = !in_range;
                    if (!in_range)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (aper_reg)
                    begin
                        f_next     = idx_ext[AW-1:0];
                        j_next     = '0;
                        cnt_next   = len_minus_idx;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        f_next     = '0;
                        j_next     = (idx_ext == '0) ? '0 : len_minus_idx[AW-1:0];
                        cnt_next   = len_eff;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                f_next   = f_reg + AW'(1);
                j_next   = (j_inc == len_eff) ? '0 : j_inc[AW-1:0];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= rd_en;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        f_reg     <= f_next;
        j_reg     <= j_next;
        cnt_reg   <= cnt_next;
        shift_reg <= shift_next;
        oor_reg   <= oor_next;
    end

    // element store
    bsc_ram #(
        .DEPTH (MAX_LENGTH),
        .AW    (AW)
    ) u_ram (
        .clk    (clk),
        .we     (wr_en),
        .waddr  (idx_ext[AW-1:0]),
        .wdata  ({s_tdata[IDX_W+1], s_tdata[IDX_W]}),
        .raddr0 (f_reg),
        .raddr1 (j_reg),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // shared accumulator
    assign acc_ctrl.clear    = accept & is_query;
    assign acc_ctrl.add      = dv_reg;
    assign acc_ctrl.auto_sel = auto_reg;

    bsc_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .rdata0 (rdata0),
        .rdata1 (rdata1),
        .acc    (acc)
    );

    // result
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {2'b00, acc, shift_reg};
    assign m_tuser  = oor_reg;

endmodule

// ----- hdl/bsc_checker.sv -----
module bsc_checker
    import bsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // no new request while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
    else $error("ready while result pending");

    // a query keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
    else $error("ready right after query");

    // a load leaves the block ready and makes no result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_LOAD) |=> s_tready && !m_tvalid)
    else $error("load stalled or produced a result");

    // out-of-range result carries zero correlation
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[21:10] == 12'd0))
    else $error("out-of-range result not zero");

endmodule

bind binary_sequence_correlator bsc_checker u_bsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_binary_sequence_correlator.sv -----
module tb_binary_sequence_correlator;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int MAX_LEN       = DEFAULT_MAX_LENGTH;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 1100;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int PRESSURE_PHASE = 4;
    localparam int N_DIRECTED    = 28;
    localparam int N_PHASES      = 10;
    localparam int FULL_FILL_MAX = 256;
    localparam int END_FILL      = 24;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    // reg_sel is only used by register rows, value is the register data or the index
    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_sel;
        logic                     op;
        logic [LEN_W-1:0]         value;
        logic                     bit_a;
        logic                     bit_b;
        logic                     typed;
        logic signed [CORR_W-1:0] corr;
        logic                     oor;
    } directed_row_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             aperiodic;
        logic             auto_sel;
        logic             anti;      // fill b as the complement of a
        logic [9:0]       count;
    } phase_t;

    typedef struct packed {
        logic [IDX_W-1:0]         shift;
        logic signed [CORR_W-1:0] corr;
        logic                     oor;
    } corr_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // index[9:0], bit_a[10], bit_b[11], zero pad
    logic                 s_tuser;   // operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // shift[9:0], correlation[21:10], zero pad
    logic                 m_tuser;   // shift_out_of_range
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    // predictor state
    logic        seq_a [MAX_LEN];
    logic        seq_b [MAX_LEN];
    bit          loaded [MAX_LEN];
    int unsigned eff_len;
    logic        aper_mode;
    logic        auto_sel;

    corr_result_t pending_results [$];

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    bit          hold_pending;
    int          hold_left;
    int          failures;
    int          requests;
    int          results_checked;
    int          cfg_writes;

    directed_row_t directed_rows [N_DIRECTED] = '{
        // length 4, periodic, auto
        '{ROW_CFG, REG_LENGTH,    OP_LOAD,  11'd4,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_CFG, REG_APERIODIC, OP_LOAD,  11'd0,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_CFG, REG_AUTO,      OP_LOAD,  11'd1,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        // every bit pair, then loads beyond the length that must change nothing
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd0,    1'b1, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd1,    1'b0, 1'b1, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd2,    1'b1, 1'b1, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd3,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd4,    1'b1, 1'b1, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd1023, 1'b1, 1'b1, 1'b0, 12'sd0, 1'b0},
        // auto at shift zero gives the length; shifts at or past it are out of range
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd0,    1'b0, 1'b0, 1'b1, 12'sd4, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd1,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd3,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd4,    1'b0, 1'b0, 1'b1, 12'sd0, 1'b1},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd1023, 1'b1, 1'b1, 1'b1, 12'sd0, 1'b1},
        // cross correlation, periodic then aperiodic, then aperiodic auto
        '{ROW_CFG, REG_AUTO,      OP_LOAD,  11'd0,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd0,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd2,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_CFG, REG_APERIODIC, OP_LOAD,  11'd1,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd0,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd3,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_CFG, REG_AUTO,      OP_LOAD,  11'd1,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd3,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        // zero length: loads ignored, every query out of range
        '{ROW_CFG, REG_LENGTH,    OP_LOAD,  11'd0,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_LOAD,  11'd0,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd0,    1'b0, 1'b0, 1'b1, 12'sd0, 1'b1},
        // length one keeps the earlier element zero
        '{ROW_CFG, REG_LENGTH,    OP_LOAD,  11'd1,    1'b0, 1'b0, 1'b0, 12'sd0, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd0,    1'b0, 1'b0, 1'b1, 12'sd1, 1'b0},
        '{ROW_REQ, REG_LENGTH,    OP_QUERY, 11'd1,    1'b1, 1'b0, 1'b1, 12'sd0, 1'b1}
    };

    // length, aperiodic, auto, complement fill, random requests
    phase_t phases [N_PHASES] = '{
        '{11'd16,   1'b0, 1'b1, 1'b0, 10'd60},
        '{11'd16,   1'b1, 1'b0, 1'b0, 10'd60},
        '{11'd7,    1'b0, 1'b0, 1'b0, 10'd50},
        '{11'd1,    1'b1, 1'b1, 1'b0, 10'd30},
        '{11'd2,    1'b0, 1'b0, 1'b0, 10'd40},
        '{11'd64,   1'b1, 1'b0, 1'b0, 10'd50},
        '{11'd100,  1'b0, 1'b1, 1'b0, 10'd30},
        '{11'd2047, 1'b1, 1'b0, 1'b1, 10'd30},
        '{11'd1024, 1'b1, 1'b1, 1'b0, 10'd18},
        '{11'd5,    1'b0, 1'b1, 1'b0, 10'd18}
    };

    binary_sequence_correlator #(
        .MAX_LENGTH (MAX_LEN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] sel, logic [LEN_W-1:0] value);
        case (sel)
            REG_LENGTH:    eff_len = (value > MAX_LEN) ? MAX_LEN : value;
            REG_APERIODIC: aper_mode = value[0];
            REG_AUTO:      auto_sel = value[0];
            default:       ;
        endcase
    endfunction

    // signed sum of products, cyclic or truncated overlap
    function automatic logic signed [CORR_W-1:0] correlation_at(int unsigned shift);
        int          acc;
        int unsigned j;
        logic        partner;
        acc = 0;
        for (int unsigned f = 0; f < eff_len; f++)
        begin
            if (f >= shift)
                j = f - shift;
            else if (aper_mode)
                continue;
            else
                j = f + eff_len - shift;
            partner = auto_sel ? seq_a[j] : seq_b[j];
            acc += (seq_a[f] == partner) ? 1 : -1;
        end
        return CORR_W'(acc);
    endfunction

    // true when every element that a query at this shift reads has been written
    function automatic bit reads_loaded(int unsigned shift);
        int unsigned j;
        if (shift >= eff_len)
            return 1'b1;
        for (int unsigned f = 0; f < eff_len; f++)
        begin
            if (f >= shift)
                j = f - shift;
            else if (aper_mode)
                continue;
            else
                j = f + eff_len - shift;
            if (!loaded[f] || !loaded[j])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // updates the stores; returns 1 with the result when the request is a query
    function automatic bit predict_request(logic op, logic [IDX_W-1:0] idx, logic a, logic b,
                                           output corr_result_t res);
        res = '0;
        if (op == OP_LOAD)
        begin
            if (idx < eff_len)
            begin
                seq_a[idx]  = a;
                seq_b[idx]  = b;
                loaded[idx] = 1'b1;
            end
            return 1'b0;
        end
        res.shift = idx;
        if (idx >= eff_len)
            res.oor = 1'b1;
        else
            res.corr = correlation_at(idx);
        return 1'b1;
    endfunction

    // compare one result with the oldest outstanding query
    function automatic void check_result(logic [23:0] data, logic flag);
        corr_result_t want;
        if (pending_results.size() == 0)
        begin
            note_failure($sformatf("result shift %0d with no query outstanding", data[9:0]));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (data[9:0] !== want.shift)
            note_failure($sformatf("result %0d shift expected %0d got %0d",
                                   results_checked, want.shift, data[9:0]));
        if (data[21:10] !== want.corr)
            note_failure($sformatf("result %0d correlation expected %0d got %0d",
                                   results_checked, want.corr, $signed(data[21:10])));
        if (flag !== want.oor)
            note_failure($sformatf("result %0d out-of-range flag expected %0b got %0b",
                                   results_checked, want.oor, flag));
    endfunction

    // result side: checking, random stalls and the long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (hold_pending)
            begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // one request, with random idle cycles before it
    task automatic send_request(logic op, logic [IDX_W-1:0] idx, logic a, logic b,
                                bit typed = 1'b0, logic signed [CORR_W-1:0] corr = '0,
                                logic oor = 1'b0);
        corr_result_t res;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, b, a, idx};
        do
            @(posedge clk);
        while (!s_tready);
        requests++;
        if (predict_request(op, idx, a, b, res))
        begin
            if (typed)
            begin
                res.corr = corr;
                res.oor  = oor;
            end
            pending_results.push_back(res);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] sel, logic [LEN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        apply_register(sel, value);
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // write every element in use that was never written, or all of them for a complement fill;
    // a long sequence gets only its two ends
    task automatic fill_store(bit anti);
        logic a;
        for (int i = 0; i < eff_len; i++)
        begin
            if (eff_len > FULL_FILL_MAX && i >= END_FILL && i < int'(eff_len) - END_FILL)
                continue;
            if (anti || !loaded[i])
            begin
                a = 1'($urandom_range(1));
                send_request(OP_LOAD, IDX_W'(i), a, anti ? ~a : 1'($urandom_range(1)));
            end
        end
    endtask

    // mostly in-range indexes, the rest anywhere in the field; queries only read written ends
    task automatic send_random_request();
        logic [IDX_W-1:0] idx;
        logic             op;
        op = ($urandom_range(99) < 45) ? OP_LOAD : OP_QUERY;
        if ($urandom_range(99) < 85)
            idx = IDX_W'($urandom_range(eff_len - 1));
        else
            idx = IDX_W'($urandom_range(MAX_LEN - 1));
        if (op == OP_QUERY && !reads_loaded(idx))
            idx = IDX_W'(eff_len - 1 - $urandom_range(END_FILL - 1));
        send_request(op, idx, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // stimulus
    initial
    begin
        int waited;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_LOAD;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_LENGTH;
        cfg_data     = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_pending = 1'b0;
        hold_left    = 0;
        failures     = 0;
        requests     = 0;
        results_checked = 0;
        cfg_writes   = 0;
        eff_len      = RST_LENGTH;
        aper_mode    = RST_APERIODIC;
        auto_sel     = RST_AUTO;
        foreach (loaded[i])
        begin
            loaded[i] = 1'b0;
            seq_a[i]  = 1'b0;
            seq_b[i]  = 1'b0;
        end

        // reset
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                repeat (SETTLE_CYCLES) @(posedge clk);
                write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else
                send_request(directed_rows[i].op, directed_rows[i].value[IDX_W-1:0],
                             directed_rows[i].bit_a, directed_rows[i].bit_b,
                             directed_rows[i].typed, directed_rows[i].corr,
                             directed_rows[i].oor);
        end

        // random phases over several register settings
        foreach (phases[p])
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 72; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 72; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            write_register(REG_LENGTH, phases[p].length);
            write_register(REG_APERIODIC, LEN_W'(phases[p].aperiodic));
            write_register(REG_AUTO, LEN_W'(phases[p].auto_sel));
            fill_store(phases[p].anti);

            // first, last and first out-of-range shift
            if (reads_loaded(0))
                send_request(OP_QUERY, '0, 1'b0, 1'b1);
            send_request(OP_QUERY, IDX_W'(eff_len - 1), 1'b1, 1'b0);
            if (eff_len < MAX_LEN)
                send_request(OP_QUERY, IDX_W'(eff_len), 1'b1, 1'b1);

            // receiver holds off while queries keep coming
            if (p == PRESSURE_PHASE)
                hold_pending = 1'b1;

            for (int n = 0; n < phases[p].count; n++)
            begin
                if (p % 2 == 1 && n == phases[p].count / 2)
                    drain_results();
                send_random_request();
            end
        end

        // wait for the last results
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d queries never answered", pending_results.size()));

        $display("%0d requests under %0d register writes, %0d results compared, %0d failures",
                 requests, cfg_writes, results_checked, failures);
        $display("lengths 0 to 2047, both modes, auto and cross, stalls and a long hold-off");
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bsc_pkg.sv
hdl/bsc_ram.sv
hdl/bsc_accum.sv
hdl/binary_sequence_correlator.sv
hdl/bsc_checker.sv
tb/sv/tb_binary_sequence_correlator.sv
